@@ hw/rtl/mrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrs_pkg
// Types, constants and register indexes shared by the motor reversing
// sequencer modules.
// ----------------------------------------------------------------------------
package mrs_pkg;

    // timing of the sequencer, in input ticks and milliseconds
    localparam int unsigned TICKS_PER_STEP = 10;
    localparam int unsigned STEP_MS        = 10;
    localparam int unsigned AVG_LEN_LOG2   = 4;
    localparam int unsigned AVG_LEN        = 1 << AVG_LEN_LOG2;

    localparam int unsigned BASE_TIMEOUT_MS = 100;
    localparam int unsigned FWD_RAMP_STEPS  = 32;

    localparam int unsigned DUTY_W    = 12;
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned EXTRA_W   = 13;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned STEPS_W   = 8;
    localparam int unsigned SHIFT_W   = 4;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned SCOUNT_W  = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    // register reset values
    localparam logic [MS_W-1:0]    REVERSE_TIMEOUT_RST  = 16'd3000;
    localparam logic [MS_W-1:0]    WAIT_FWD_TIMEOUT_RST = 16'd1000;
    localparam logic [STEPS_W-1:0] SOFT_START_STEPS_RST = 8'd32;
    localparam logic [SHIFT_W-1:0] SOFT_START_SHIFT_RST = 4'd5;

    typedef enum logic [1:0] {
        PH_REVERSE      = 2'd0,
        PH_WAIT_REVERSE = 2'd1,
        PH_FORWARD      = 2'd2,
        PH_WAIT_FORWARD = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_DUTY      = 3'd0,
        CFG_REVERSE_DUTY      = 3'd1,
        CFG_FORWARD_EXTRA     = 3'd2,
        CFG_WAIT_REV_EXTRA    = 3'd3,
        CFG_REVERSE_TIMEOUT   = 3'd4,
        CFG_WAIT_FWD_TIMEOUT  = 3'd5,
        CFG_SOFT_START_STEPS  = 3'd6,
        CFG_SOFT_START_SHIFT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  forward_duty;
        logic [DUTY_W-1:0]  reverse_duty;
        logic [EXTRA_W-1:0] forward_extra_ms;
        logic [EXTRA_W-1:0] wait_reverse_extra_ms;
        logic [MS_W-1:0]    reverse_timeout_ms;
        logic [MS_W-1:0]    wait_forward_timeout_ms;
        logic [STEPS_W-1:0] soft_start_steps;
        logic [SHIFT_W-1:0] soft_start_shift;
    } mrs_cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic                entry_pending;
        logic [MS_W-1:0]     elapsed_ms;
        logic [MS_W-1:0]     phase_timeout;
        logic [STEPS_W-1:0]  ramp_count;
        logic [DUTY_W-1:0]   duty;
        logic [TICK_W-1:0]   tick_divider;
        logic [SUM_W-1:0]    pot_one_sum;
        logic [SUM_W-1:0]    pot_two_sum;
        logic [SCOUNT_W-1:0] sample_count;
        logic [SAMPLE_W-1:0] pot_one_avg;
        logic [SAMPLE_W-1:0] pot_two_avg;
        logic                pwm_running;
        logic                driver_enable;
        logic                averages_ready;
    } mrs_state_t;

    typedef struct packed {
        logic              driver_on;
        logic              pwm_on;
        logic              direction_forward;
        phase_t            phase;
        logic [DUTY_W-1:0] duty;
    } mrs_result_t;

endpackage

@@ hw/rtl/mrs_step.sv @@
// ----------------------------------------------------------------------------
// mrs_step
// Next-state logic for one tick: step strobe, phase entry, ramp, exit test
// and pot averaging.
// ----------------------------------------------------------------------------
module mrs_step
    import mrs_pkg::*;
(
    input  mrs_state_t           state_i,
    input  mrs_cfg_t             cfg_i,
    input  logic [SAMPLE_W-1:0]  pot_one_sample,
    input  logic [SAMPLE_W-1:0]  pot_two_sample,
    input  logic                 limit_low,
    output mrs_state_t           state_o,
    output mrs_result_t          result_o
);

    always_comb begin
        mrs_state_t          st;
        logic [TICK_W:0]     tick_inc;
        logic                strobe;
        logic [MS_W:0]       elapsed_sum;
        logic [DUTY_W-1:0]   target;
        logic [DUTY_W:0]     duty_sum;
        logic [SAMPLE_W+EXTRA_W-1:0] scale_prod;
        logic [SAMPLE_W-1:0] scale_avg;
        logic [EXTRA_W-1:0]  scale_extra;
        logic                leave;
        logic [SCOUNT_W:0]   sc_inc;

        st = state_i;

        tick_inc = (TICK_W+1)'(st.tick_divider) + 1'b1;
        strobe   = tick_inc >= (TICK_W+1)'(TICKS_PER_STEP);
        st.tick_divider = strobe ? '0 : tick_inc[TICK_W-1:0];

        // scaled timeout for the two pot-controlled phases
        if (st.phase == PH_WAIT_REVERSE) begin
            scale_extra = cfg_i.wait_reverse_extra_ms;
            scale_avg   = st.pot_two_avg;
        end else begin
            scale_extra = cfg_i.forward_extra_ms;
            scale_avg   = st.pot_one_avg;
        end
        scale_prod = (SAMPLE_W+EXTRA_W)'(scale_extra) * (SAMPLE_W+EXTRA_W)'(scale_avg);

        if (st.entry_pending) begin
            st.entry_pending = 1'b0;
            st.elapsed_ms    = '0;
            unique case (st.phase)
                PH_REVERSE: begin
                    st.phase_timeout = cfg_i.reverse_timeout_ms;
                    st.ramp_count    = cfg_i.soft_start_steps;
                    st.duty          = '0;
                end
                PH_FORWARD: begin
                    st.phase_timeout = MS_W'(scale_prod[SAMPLE_W+EXTRA_W-1:SAMPLE_W])
                                       + MS_W'(BASE_TIMEOUT_MS);
                    st.ramp_count    = STEPS_W'(FWD_RAMP_STEPS);
                    st.duty          = '0;
                end
                PH_WAIT_REVERSE: begin
                    st.phase_timeout = MS_W'(scale_prod[SAMPLE_W+EXTRA_W-1:SAMPLE_W])
                                       + MS_W'(BASE_TIMEOUT_MS);
                end
                PH_WAIT_FORWARD: begin
                    st.phase_timeout = cfg_i.wait_forward_timeout_ms;
                end
            endcase
        end

        target = (st.phase == PH_FORWARD) ? cfg_i.forward_duty : cfg_i.reverse_duty;
        duty_sum = (DUTY_W+1)'(st.duty) + (DUTY_W+1)'(target >> cfg_i.soft_start_shift);
        elapsed_sum = (MS_W+1)'(st.elapsed_ms) + (MS_W+1)'(STEP_MS);

        if (strobe) begin
            st.elapsed_ms = elapsed_sum[MS_W] ? '1 : elapsed_sum[MS_W-1:0];
            if (st.phase == PH_REVERSE || st.phase == PH_FORWARD) begin
                if (st.ramp_count != '0 &&
                    target > DUTY_W'(cfg_i.soft_start_steps)) begin
                    st.ramp_count = st.ramp_count - 1'b1;
                    st.duty       = duty_sum[DUTY_W] ? '1 : duty_sum[DUTY_W-1:0];
                end else begin
                    st.duty = target;
                end
            end
        end

        leave = st.elapsed_ms > st.phase_timeout;
        unique case (st.phase)
            PH_REVERSE: begin
                if (leave || !limit_low) begin
                    st.pwm_running   = 1'b0;
                    st.driver_enable = 1'b0;
                    st.phase         = PH_WAIT_REVERSE;
                end
            end
            PH_WAIT_REVERSE: begin
                if (leave) begin
                    st.pwm_running = 1'b1;
                    st.phase       = PH_FORWARD;
                end
            end
            PH_FORWARD: begin
                if (leave) begin
                    st.pwm_running = 1'b0;
                    st.phase       = PH_WAIT_FORWARD;
                end
            end
            PH_WAIT_FORWARD: begin
                if (leave) begin
                    st.duty          = '0;
                    st.pwm_running   = 1'b1;
                    st.driver_enable = 1'b1;
                    st.phase         = PH_REVERSE;
                end
            end
        endcase
        if (st.phase != state_i.phase) begin
            st.entry_pending = 1'b1;
            st.elapsed_ms    = '0;
        end

        // block averages over the pot samples
        st.pot_one_sum = st.pot_one_sum + SUM_W'(pot_one_sample);
        st.pot_two_sum = st.pot_two_sum + SUM_W'(pot_two_sample);
        sc_inc = (SCOUNT_W+1)'(st.sample_count) + 1'b1;
        if (sc_inc >= (SCOUNT_W+1)'(AVG_LEN)) begin
            st.sample_count = '0;
            st.pot_one_avg  = SAMPLE_W'(st.pot_one_sum >> AVG_LEN_LOG2);
            st.pot_two_avg  = SAMPLE_W'(st.pot_two_sum >> AVG_LEN_LOG2);
            st.pot_one_sum  = '0;
            st.pot_two_sum  = '0;
            if (!st.averages_ready) begin
                st.averages_ready = 1'b1;
                st.driver_enable  = 1'b1;
            end
        end else begin
            st.sample_count = sc_inc[SCOUNT_W-1:0];
        end

        state_o = st;
        result_o.duty              = st.duty;
        result_o.phase             = st.phase;
        result_o.direction_forward = (st.phase == PH_FORWARD) ||
                                     (st.phase == PH_WAIT_FORWARD);
        result_o.pwm_on            = st.pwm_running;
        result_o.driver_on         = st.driver_enable;
    end

endmodule

@@ hw/rtl/motor_reversing_sequencer.sv @@
// ----------------------------------------------------------------------------
// motor_reversing_sequencer
// Reverse / pause / forward / pause motor sequencer with soft-start duty ramp,
// driven by one input item per 1 ms tick.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and gives one result
// per item; each item passes through the input register and then the result
// register before it is valid on the output. The rate is set by the state
// update in mrs_step, which sits between the input register and the result
// register; each item reads the state left by the one before it.
// Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata
// and must only change while no item is in flight.
module motor_reversing_sequencer
    import mrs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [11:0] pot_one_sample, [23:12] pot_two_sample, [24] limit_low
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [11:0] duty, [13:12] phase, [14] direction_forward, [15] pwm_on,
    // [16] driver_on
    output logic [M_TDATA_W-1:0]   m_axis_tdata
);

    mrs_cfg_t            cfg_reg;
    mrs_state_t          state_reg;
    mrs_state_t          state_next;
    mrs_result_t         result_next;
    mrs_result_t         out_data_reg;
    logic                out_valid_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] pot_one_reg;
    logic [SAMPLE_W-1:0] pot_two_reg;
    logic                limit_low_reg;
    logic                advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.forward_duty            <= '0;
            cfg_reg.reverse_duty            <= '0;
            cfg_reg.forward_extra_ms        <= '0;
            cfg_reg.wait_reverse_extra_ms   <= '0;
            cfg_reg.reverse_timeout_ms      <= REVERSE_TIMEOUT_RST;
            cfg_reg.wait_forward_timeout_ms <= WAIT_FWD_TIMEOUT_RST;
            cfg_reg.soft_start_steps        <= SOFT_START_STEPS_RST;
            cfg_reg.soft_start_shift        <= SOFT_START_SHIFT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_FORWARD_DUTY:     cfg_reg.forward_duty <= cfg_wdata[DUTY_W-1:0];
                CFG_REVERSE_DUTY:     cfg_reg.reverse_duty <= cfg_wdata[DUTY_W-1:0];
                CFG_FORWARD_EXTRA:    cfg_reg.forward_extra_ms <= cfg_wdata[EXTRA_W-1:0];
                CFG_WAIT_REV_EXTRA:   cfg_reg.wait_reverse_extra_ms <= cfg_wdata[EXTRA_W-1:0];
                CFG_REVERSE_TIMEOUT:  cfg_reg.reverse_timeout_ms <= cfg_wdata[MS_W-1:0];
                CFG_WAIT_FWD_TIMEOUT: cfg_reg.wait_forward_timeout_ms <= cfg_wdata[MS_W-1:0];
                CFG_SOFT_START_STEPS: cfg_reg.soft_start_steps <= cfg_wdata[STEPS_W-1:0];
                CFG_SOFT_START_SHIFT: cfg_reg.soft_start_shift <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            pot_one_reg   <= s_axis_tdata[SAMPLE_W-1:0];
            pot_two_reg   <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            limit_low_reg <= s_axis_tdata[2*SAMPLE_W];
        end
    end

    mrs_step u_step (
        .state_i        (state_reg),
        .cfg_i          (cfg_reg),
        .pot_one_sample (pot_one_reg),
        .pot_two_sample (pot_two_reg),
        .limit_low      (limit_low_reg),
        .state_o        (state_next),
        .result_o       (result_next)
    );

    // sequencer state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '{phase:         PH_REVERSE,
                               entry_pending: 1'b1,
                               phase_timeout: MS_W'(BASE_TIMEOUT_MS),
                               pwm_running:   1'b1,
                               default:       '0};
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_data_reg.driver_on, out_data_reg.pwm_on,
                            out_data_reg.direction_forward, out_data_reg.phase,
                            out_data_reg.duty};

endmodule
